// ===== sv/mbx_pkg.sv =====
// Shared widths, codes and types for the MIDI byte extractor and its slot queue.
package mbx_pkg;

   localparam int ByteWidth        = 8;
   localparam int PhaseWidth       = 3;
   localparam int DefaultRingDepth = 64;

   localparam logic [ByteWidth-1:0] MaskReset = 8'h01;

   localparam logic [1:0] SHIFT_NONE = 2'd0;
   localparam logic [1:0] SHIFT_ONE  = 2'd1;
   localparam logic [1:0] SHIFT_TWO  = 2'd2;

   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [PhaseWidth-1:0] phase_type;

   typedef struct packed {
      logic       push;
      logic [1:0] shift;
      byte_type   data;
   } cell_ctrl_type;

   typedef struct packed {
      logic     overflow;
      byte_type midi_byte;
      logic     midi_present;
      logic     slot_boundary;
   } rsp_type;

endpackage

// ===== sv/mbx_cell.sv =====
// One queue cell: holds a byte and its valid bit, refilled from the cells above or the input.
module mbx_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  mbx_pkg::cell_ctrl_type ctrl,
   input  logic                   prev_vld,
   input  logic                   nxt1_vld,
   input  logic                   nxt2_vld,
   input  mbx_pkg::byte_type      nxt1_dat,
   input  mbx_pkg::byte_type      nxt2_dat,
   output logic                   vld,
   output mbx_pkg::byte_type      dat
);
   import mbx_pkg::*;

   logic     vld_ff;
   logic     vld_in;
   byte_type dat_ff;
   byte_type dat_in;
   logic     src_vld;
   byte_type src_dat;
   logic     tail;

   always_comb begin
      unique case (ctrl.shift)
         SHIFT_ONE: begin
            src_vld = nxt1_vld;
            src_dat = nxt1_dat;
            tail    = ctrl.push && vld_ff && !nxt1_vld;
         end
         SHIFT_TWO: begin
            src_vld = nxt2_vld;
            src_dat = nxt2_dat;
            tail    = ctrl.push && nxt1_vld && !nxt2_vld;
         end
         default: begin
            src_vld = vld_ff;
            src_dat = dat_ff;
            tail    = ctrl.push && prev_vld && !vld_ff;
         end
      endcase
      vld_in = src_vld || tail;
      dat_in = src_vld ? src_dat : ctrl.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      dat_ff <= dat_in;
   end

   assign vld = vld_ff;
   assign dat = dat_ff;

endmodule

// ===== sv/midi_byte_extract_fifo_slotter.sv =====
// Top level of the MIDI byte extractor: key match, slot counter, cell queue and output stage.
//
// Usage. Each req transaction carries one stream event: key_byte in req_tdata[7:0],
// data_byte in req_tdata[15:8] and packet_start in req_tuser. When every bit of the
// key mask is set in key_byte, data_byte enters a queue of RING_DEPTH-1 cells; a push
// into a full queue drops the oldest byte and raises overflow. Every eighth event of
// a packet is a slot that pops the oldest byte. Each event gives one rsp transaction
// with midi_byte in rsp_tdata and slot_boundary, midi_present, overflow in rsp_tuser.
// The key mask is written through the csr channel, which is always ready; write it
// only while no event is in flight.
// The response is registered, and one event is taken in every cycle while req_tready
// is high. The queue cells update together in the accepting cycle, each cell keeping
// its byte or taking one from one of the two cells above it or from the input.
// Reset empties the queue, restarts the slot count and sets the mask to 1.
// When the receiver stalls, a second output register takes one more event; req_tready
// falls only while both output registers are full.
module midi_byte_extract_fifo_slotter #(
   parameter int RING_DEPTH = mbx_pkg::DefaultRingDepth
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [15:0]               req_tdata,  // key_byte, data_byte
   input  logic [0:0]                req_tuser,  // packet_start
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,  // midi_byte
   output logic [2:0]                rsp_tuser,  // slot_boundary, midi_present, overflow
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  mbx_pkg::byte_type         csr_data
);
   import mbx_pkg::*;

   localparam int Cells = RING_DEPTH - 1;

   byte_type      mask_ff;
   byte_type      mask_in;
   phase_type     phase_ff;
   phase_type     phase_in;
   phase_type     phase_eff;
   rsp_type       out_ff;
   rsp_type       out_in;
   rsp_type       skid_ff;
   rsp_type       skid_in;
   logic          out_vld_ff;
   logic          out_vld_in;
   logic          skid_vld_ff;
   logic          skid_vld_in;

   logic [Cells+1:0] vld_vec;
   byte_type         dat_ext [Cells+2];
   cell_ctrl_type    ctrl;

   logic     acc;
   logic     fire_out;
   byte_type key_byte;
   byte_type data_byte;
   logic     packet_start;
   logic     push;
   logic     ovf;
   logic     boundary;
   logic     head_vld;
   byte_type head_dat;
   logic     present;
   logic     pop;
   rsp_type  new_rsp;

   assign req_tready = !skid_vld_ff;
   assign csr_ready  = 1'b1;
   assign acc        = req_tvalid && req_tready;
   assign fire_out   = out_vld_ff && rsp_tready;

   assign key_byte     = req_tdata[7:0];
   assign data_byte    = req_tdata[15:8];
   assign packet_start = req_tuser[0];

   assign vld_vec[Cells+1:Cells] = 2'b00;
   assign dat_ext[Cells]         = '0;
   assign dat_ext[Cells+1]       = '0;

   always_comb begin
      push      = acc && ((key_byte & mask_ff) == mask_ff);
      ovf       = push && vld_vec[Cells-1];
      phase_eff = packet_start ? '0 : phase_ff;
      boundary  = (phase_eff == '0);
      head_vld  = ovf ? vld_vec[1] : vld_vec[0];
      head_dat  = ovf ? dat_ext[1] : dat_ext[0];
      present   = boundary && (head_vld || push);
      pop       = acc && present;

      ctrl.push = push;
      ctrl.data = data_byte;
      if (ovf && pop) begin
         ctrl.shift = SHIFT_TWO;
      end else if (ovf || pop) begin
         ctrl.shift = SHIFT_ONE;
      end else begin
         ctrl.shift = SHIFT_NONE;
      end

      new_rsp.slot_boundary = boundary;
      new_rsp.midi_present  = present;
      new_rsp.midi_byte     = present ? (head_vld ? head_dat : data_byte) : '0;
      new_rsp.overflow      = ovf;

      phase_in = acc ? phase_eff + 1'b1 : phase_ff;
      mask_in  = (csr_valid && csr_ready) ? csr_data : mask_ff;
   end

   for (genvar g = 0; g < Cells; g++) begin : g_cell
      logic prev_vld;
      if (g == 0) begin : g_first
         assign prev_vld = 1'b1;
      end else begin : g_rest
         assign prev_vld = vld_vec[g-1];
      end
      mbx_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .prev_vld (prev_vld),
         .nxt1_vld (vld_vec[g+1]),
         .nxt2_vld (vld_vec[g+2]),
         .nxt1_dat (dat_ext[g+1]),
         .nxt2_dat (dat_ext[g+2]),
         .vld      (vld_vec[g]),
         .dat      (dat_ext[g])
      );
   end

   always_comb begin
      out_in      = out_ff;
      skid_in     = skid_ff;
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         if (fire_out) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (acc) begin
         if (!out_vld_ff || fire_out) begin
            out_in     = new_rsp;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = new_rsp;
            skid_vld_in = 1'b1;
         end
      end else if (fire_out) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff     <= MaskReset;
         phase_ff    <= '0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         mask_ff     <= mask_in;
         phase_ff    <= phase_in;
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff.midi_byte;
   assign rsp_tuser  = {out_ff.overflow, out_ff.midi_present, out_ff.slot_boundary};

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("Skid register holds a transaction while the output register is empty.");

   a_queue_packed: assert property (@(posedge clock) disable iff (reset)
      !vld_vec[0] |-> (vld_vec == '0))
      else $error("Queue cells hold a byte above an empty head cell.");

   a_present_on_slot: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (!out_ff.midi_present || out_ff.slot_boundary))
      else $error("MIDI byte given outside a slot boundary.");

   a_phase_restart: assert property (@(posedge clock) disable iff (reset)
      (acc && packet_start) |=> (phase_ff == phase_type'(1)))
      else $error("Slot count did not restart on a packet start.");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the MIDI byte extractor with its eighth-slot byte queue.
`timescale 1ns / 100ps

module tb_top;
   import mbx_pkg::*;

   localparam int RingDepth  = DefaultRingDepth;
   localparam int PtrWidth   = $clog2(RingDepth);
   localparam int LongHold   = 150;
   localparam int QuietLimit = 2000;
   localparam int PhaseCount = 6;

   typedef struct {
      byte_type key;
      byte_type data;
      logic     start;
   } stream_event_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [15:0] req_tdata = '0;  // key_byte, data_byte
   logic [0:0] req_tuser = '0;   // packet_start
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;        // midi_byte
   logic [2:0] rsp_tuser;        // slot_boundary, midi_present, overflow
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   byte_type   csr_data = '0;

   midi_byte_extract_fifo_slotter #(
      .RING_DEPTH(RingDepth)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Predictor state.
   byte_type            ring_bytes [RingDepth];
   logic [PtrWidth-1:0] ring_wr = '0;
   logic [PtrWidth-1:0] ring_rd = '0;
   phase_type           slot_count = '0;
   byte_type            key_mask = MaskReset;

   stream_event_type events_pending[$];
   rsp_type          slot_results_due[$];
   stream_event_type req_item;
   stream_event_type next_event;
   int unsigned      req_gap = 0;
   int unsigned      rsp_wait = 0;
   int unsigned      rsp_draw;
   int unsigned      hold_left = 0;
   logic             hold_request = 1'b0;
   logic             hold_seen = 1'b0;
   logic             req_idle_on = 1'b1;
   logic             rsp_idle_on = 1'b1;
   int unsigned      quiet_cycles = 0;
   int               mismatch_count = 0;
   int               event_count = 0;
   int               popped_count = 0;
   int               empty_slot_count = 0;
   int               overflow_count = 0;

   byte_type    phase_mask [PhaseCount];
   int unsigned phase_items [PhaseCount] = '{120, 150, 200, 200, 200, 180};
   int unsigned phase_match [PhaseCount] = '{100, 50, 90, 30, 60, 75};
   logic        phase_req_idle [PhaseCount] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
   logic        phase_rsp_idle [PhaseCount] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

   task automatic predict_slot_result(input stream_event_type ev);
      rsp_type r;
      r = '0;
      if (ev.start) begin
         slot_count = '0;
      end
      if ((ev.key & key_mask) == key_mask) begin
         ring_bytes[ring_wr] = ev.data;
         ring_wr = ring_wr + 1'b1;
         if (ring_wr == ring_rd) begin
            ring_rd = ring_rd + 1'b1;
            r.overflow = 1'b1;
            overflow_count++;
         end
      end
      if (slot_count == '0) begin
         r.slot_boundary = 1'b1;
         if (ring_wr != ring_rd) begin
            r.midi_byte = ring_bytes[ring_rd];
            r.midi_present = 1'b1;
            ring_rd = ring_rd + 1'b1;
            popped_count++;
         end else begin
            empty_slot_count++;
         end
      end
      slot_count = slot_count + 1'b1;
      event_count++;
      slot_results_due.push_back(r);
   endtask

   function automatic void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic check_slot_result();
      rsp_type want;
      if (slot_results_due.size() == 0) begin
         $error("unexpected result transaction: midi_byte %0d, flags %b", rsp_tdata, rsp_tuser);
         mismatch_count++;
      end else begin
         want = slot_results_due.pop_front();
         compare_field("slot_boundary", want.slot_boundary, rsp_tuser[0]);
         compare_field("midi_present", want.midi_present, rsp_tuser[1]);
         compare_field("overflow", want.overflow, rsp_tuser[2]);
         compare_field("midi_byte", want.midi_byte, rsp_tdata);
      end
   endtask

   // Driver: offers pending events, with a random gap after each one while req_idle_on is set.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_slot_result(req_item);
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (events_pending.size() != 0) begin
               next_event = events_pending.pop_front();
               req_item <= next_event;
               req_tdata <= {next_event.data, next_event.key};
               req_tuser <= next_event.start;
               req_tvalid <= 1'b1;
               req_gap <= req_idle_on ? $urandom_range(0, 4) : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor and receiver: checks each result and stalls at random or for a long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait <= 0;
         hold_left <= 0;
         hold_seen <= 1'b0;
      end else begin
         hold_seen <= hold_request;
         if (rsp_tvalid && rsp_tready) begin
            check_slot_result();
         end
         if (hold_request && !hold_seen) begin
            hold_left <= LongHold;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= (hold_left == 1);
         end else if (rsp_tvalid && rsp_tready) begin
            rsp_draw = rsp_idle_on ? $urandom_range(0, 4) : 0;
            rsp_wait <= rsp_draw;
            rsp_tready <= (rsp_draw == 0);
         end else if (rsp_wait != 0) begin
            rsp_wait <= rsp_wait - 1;
            rsp_tready <= (rsp_wait == 1);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when no transaction completes for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("midi_byte_extract_fifo_slotter: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_key_mask(input byte_type mask);
      csr_valid <= 1'b1;
      csr_data <= mask;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      key_mask = mask;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (events_pending.size() != 0 || req_tvalid || slot_results_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_event(input byte_type key, input byte_type data, input logic start);
      stream_event_type ev;
      ev.key = key;
      ev.data = data;
      ev.start = start;
      events_pending.push_back(ev);
   endtask

   // Packets of random length with random content; a few short or broken packets.
   task automatic queue_packets(input int unsigned count, input int unsigned match_pct,
                                input byte_type mask);
      int unsigned left;
      int unsigned pkt_len;
      stream_event_type ev;
      left = count;
      while (left > 0) begin
         pkt_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
         for (int i = 0; i < pkt_len && left > 0; i++) begin
            ev.start = (i == 0) || ($urandom_range(0, 39) == 0);
            ev.data = byte_type'($urandom);
            if ($urandom_range(0, 99) < match_pct) begin
               ev.key = mask | byte_type'($urandom);
            end else begin
               ev.key = byte_type'($urandom);
            end
            events_pending.push_back(ev);
            left--;
         end
      end
   endtask

   initial begin
      phase_mask[0] = 8'h00;
      phase_mask[1] = 8'hFF;
      phase_mask[2] = 8'h80;
      phase_mask[3] = byte_type'($urandom);
      phase_mask[4] = byte_type'($urandom);
      phase_mask[5] = 8'h01;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // Reset mask selects key bit 0.
      add_event(8'h00, 8'hAA, 1'b1);
      add_event(8'h01, 8'hFF, 1'b0);
      add_event(8'hFE, 8'h11, 1'b0);
      add_event(8'hFF, 8'h00, 1'b0);
      add_event(8'h03, 8'h55, 1'b0);
      add_event(8'h80, 8'h12, 1'b0);
      add_event(8'h7E, 8'h34, 1'b0);
      add_event(8'h00, 8'h56, 1'b0);
      add_event(8'h00, 8'h78, 1'b0);
      add_event(8'h01, 8'hAA, 1'b1);
      add_event(8'h00, 8'h00, 1'b1);
      add_event(8'h00, 8'h00, 1'b1);
      add_event(8'h00, 8'h9A, 1'b1);
      add_event(8'h01, 8'hC3, 1'b1);
      add_event(8'hFF, 8'h3C, 1'b0);
      add_event(8'hFF, 8'h5A, 1'b0);
      wait_drained();
      for (int p = 0; p < PhaseCount; p++) begin
         write_key_mask(phase_mask[p]);
         req_idle_on <= phase_req_idle[p];
         rsp_idle_on <= phase_rsp_idle[p];
         hold_request <= (phase_mask[p] == 8'h80);
         @(negedge clock);
         queue_packets(phase_items[p], phase_match[p], phase_mask[p]);
         wait_drained();
         hold_request <= 1'b0;
      end
      if (slot_results_due.size() != 0) begin
         $error("%0d expected results never arrived", slot_results_due.size());
         mismatch_count++;
      end
      $display("Run covered %0d events under %0d key masks, with a long receiver hold.",
               event_count, PhaseCount + 1);
      $display("Slots gave %0d bytes and %0d empty outputs; %0d pushes overflowed the queue.",
               popped_count, empty_slot_count, overflow_count);
      if (mismatch_count == 0) begin
         $display("midi_byte_extract_fifo_slotter: match");
      end else begin
         $display("midi_byte_extract_fifo_slotter: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/mbx_pkg.sv
sv/mbx_cell.sv
sv/midi_byte_extract_fifo_slotter.sv
test/tb_top.sv
